// File: rtl/core/six_axis_moving_average_unit_assert.svh
// Assertion macros used by the moving-average unit.
`ifndef SIX_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define SIX_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define SMAU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SMAU_ASSERT(lbl, clk, rst_n, prop)
`define SMAU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/smau_pkg.sv
package smau_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int NUM_FIELDS       = 6;
  localparam int DEFAULT_WINDOW   = 10;
  localparam int DEFAULT_CHANNELS = 6;
  // Must be a power of two; at least the pipeline depth plus one for full rate.
  localparam int FIFO_DEPTH       = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } imu_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_accel_x;
    logic signed [SAMPLE_W-1:0] mean_accel_y;
    logic signed [SAMPLE_W-1:0] mean_accel_z;
    logic signed [SAMPLE_W-1:0] mean_gyro_x;
    logic signed [SAMPLE_W-1:0] mean_gyro_y;
    logic signed [SAMPLE_W-1:0] mean_gyro_z;
  } imu_mean_t;

endpackage

// File: rtl/core/six_axis_moving_average_unit.sv
// An accepted item passes stages s1 and s2, the mean pipeline and the output queue.
// Throughput: one item per cycle while in_ready_o is high; each item costs one history RAM read and one
// write, and per-channel running sums avoid summing the window again.
// An 8-entry output queue with credit flow control decouples the output side.
// Reset clears running sums, pointers, fill count and queue; the history RAM
// is not cleared: until the window is full, the old sample read is not subtracted.
`include "six_axis_moving_average_unit_assert.svh"

module six_axis_moving_average_unit
  import smau_pkg::*;
#(
  parameter int WINDOW   = DEFAULT_WINDOW,
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  imu_sample_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output imu_mean_t   out_data_o
);

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ROW_W  = CHANNELS * SAMPLE_W;

  logic                                 in_accept, out_accept;
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]  in_samples;
  logic [PTR_W-1:0]                     ptr_q, ptr_d;
  logic [FILL_W-1:0]                    fill_q, fill_d;
  logic                                 window_full;
  logic [OCC_W-1:0]                     occ_q, occ_d;

  logic                                 s1_valid_q, s1_old_ok_q;
  logic [PTR_W-1:0]                     s1_addr_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0]    s1_row_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0]    ram_rdata;

  logic [CHANNELS-1:0][SUM_W-1:0]       sum_q, sum_d;
  logic                                 s2_valid_q;

  logic                                 mean_valid;
  logic [CHANNELS-1:0][SAMPLE_W-1:0]    means;
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]  mean_all;
  imu_mean_t                            result;

  assign in_accept  = in_valid_i && in_ready_o;
  assign out_accept = out_valid_o && out_ready_i;
  // Credits cover every item in flight, so the queue can never overflow.
  assign in_ready_o = (occ_q < OCC_W'(FIFO_DEPTH));

  assign in_samples[0] = in_data_i.accel_x;
  assign in_samples[1] = in_data_i.accel_y;
  assign in_samples[2] = in_data_i.accel_z;
  assign in_samples[3] = in_data_i.gyro_x;
  assign in_samples[4] = in_data_i.gyro_y;
  assign in_samples[5] = in_data_i.gyro_z;

  assign window_full = (fill_q == FILL_W'(WINDOW));

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    occ_d  = occ_q + OCC_W'(in_accept) - OCC_W'(out_accept);
    if (in_accept) begin
      ptr_d = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      if (!window_full) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      fill_q     <= '0;
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      occ_q      <= occ_d;
      s1_valid_q <= in_accept;
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_addr_q   <= ptr_q;
      s1_old_ok_q <= window_full;
      s1_row_q    <= in_samples[CHANNELS-1:0];
    end
  end

  // The slot under the pointer holds the oldest sample once the window is full; it is read
  // at accept and overwritten with the new sample in the next cycle.
  smau_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_row_q),
    .re_i    (in_accept),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_d[c] = sum_q[c] + SUM_W'(signed'(s1_row_q[c]))
               - (s1_old_ok_q ? SUM_W'(signed'(ram_rdata[c])) : SUM_W'(0));
    end
  end

  smau_mean #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .sum_i   (sum_q),
    .valid_o (mean_valid),
    .mean_o  (means)
  );

  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_field
    if (f < CHANNELS) begin : g_used
      assign mean_all[f] = means[f];
    end else begin : g_unused
      assign mean_all[f] = '0;
    end
  end

  assign result.mean_accel_x = mean_all[0];
  assign result.mean_accel_y = mean_all[1];
  assign result.mean_accel_z = mean_all[2];
  assign result.mean_gyro_x  = mean_all[3];
  assign result.mean_gyro_y  = mean_all[4];
  assign result.mean_gyro_z  = mean_all[5];

  smau_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mean_valid),
    .data_i  (result),
    .pop_i   (out_accept),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  `SMAU_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OCC_W'(FIFO_DEPTH))
  `SMAU_ASSERT_NEVER(a_ram_collide, clk_i, rst_ni, in_accept && s1_valid_q && ptr_q == s1_addr_q)
  `SMAU_ASSERT(a_out_credit, clk_i, rst_ni, out_valid_o |-> occ_q != '0)
  `SMAU_ASSERT(a_fill_ptr, clk_i, rst_ni, !window_full |-> ptr_q == PTR_W'(fill_q))

endmodule

// File: rtl/core/smau_ram.sv
module smau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/smau_mean.sv
module smau_mean
  import smau_pkg::*;
#(
  parameter int WINDOW   = DEFAULT_WINDOW,
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  input  logic [CHANNELS-1:0][SAMPLE_W+$clog2(WINDOW)-1:0]     sum_i,
  output logic                                                 valid_o,
  output logic [CHANNELS-1:0][SAMPLE_W-1:0]                    mean_o
);

  localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
  // Reciprocal exact for every magnitude below 2**SUM_W, so no correction step.
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  logic va_q, vb_q, vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o = vc_q;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic                sign_a_q, sign_b_q;
    logic [SUM_W-1:0]    mag_d, mag_q;
    logic [PROD_W-1:0]   prod_d, prod_q;
    logic [SAMPLE_W-1:0] quot;
    logic [SAMPLE_W-1:0] mean_d, mean_q;

    // Divide the magnitude, then restore the sign: this truncates toward zero.
    assign mag_d  = sum_i[c][SUM_W-1] ? (~sum_i[c] + 1'b1) : sum_i[c];
    assign prod_d = PROD_W'(mag_q) * PROD_W'(RECIP_V);
    assign quot   = prod_q[RECIP_SHIFT +: SAMPLE_W];
    assign mean_d = sign_b_q ? (~quot + 1'b1) : quot;

    always_ff @(posedge clk_i) begin
      sign_a_q <= sum_i[c][SUM_W-1];
      mag_q    <= mag_d;
      sign_b_q <= sign_a_q;
      prod_q   <= prod_d;
      mean_q   <= mean_d;
    end

    assign mean_o[c] = mean_q;
  end

endmodule

// File: rtl/core/smau_fifo.sv
module smau_fifo
  import smau_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  imu_mean_t data_i,
  input  logic      pop_i,
  output logic      valid_o,
  output imu_mean_t data_o
);

  localparam int AW = $clog2(DEPTH);

  imu_mean_t     mem_q [DEPTH];
  logic [AW:0]   wr_q, wr_d, rd_q, rd_d;

  assign wr_d = push_i ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop_i ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[AW-1:0]] <= data_i;
    end
  end

  assign valid_o = (wr_q != rd_q);
  assign data_o  = mem_q[rd_q[AW-1:0]];

endmodule
